/* rtl/vesl_pkg.sv */
// Package for the vactrol envelope slew block: register codes, reset values,
// Q-format constants, controller states and the serial multiplier control word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vesl_pkg;

    // Field widths
    localparam int LVL_W   = 16;   // Q1.15 level
    localparam int RATE_W  = 28;   // Q4.24 rate
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 28;   // widest register
    localparam int CFGI_W  = 2;
    localparam int SLEW_W  = 22;   // slew factor after limiting, Q24

    // Serial multiplier sizing
    localparam int MUL_A_W   = 28;  // multiplicand
    localparam int MUL_B_W   = 32;  // multiplier shift register
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // Step counts for the three products
    localparam logic [MUL_CNT_W-1:0] STEPS_LVL = MUL_CNT_W'(16);  // 16-bit multiplier
    localparam logic [MUL_CNT_W-1:0] STEPS_SQ  = MUL_CNT_W'(31);  // level^2 multiplier

    // Constants
    localparam logic [LVL_W-1:0]  ONE_Q15  = 16'd32768;
    localparam logic [SLEW_W-1:0] SLEW_MAX = 22'd3355443;   // 0.2 in Q24, truncated

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_SUSTAIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRANSIENT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CYCLE     = 2'd2;

    // Register indexes
    localparam logic [CFGI_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_RISE_RATE  = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_FALL_RATE  = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_NEAR_FLOOR = 2'd3;

    // Register reset values
    localparam logic [MODE_W-1:0] RST_MODE       = MODE_SUSTAIN;
    localparam logic [RATE_W-1:0] RST_RISE_RATE  = 28'd58720;
    localparam logic [RATE_W-1:0] RST_FALL_RATE  = 28'd11744;
    localparam logic [LVL_W-1:0]  RST_NEAR_FLOOR = 16'd41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SQUARE,
        ST_SLEW,
        ST_STEP,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] steps;
    } mul_ctrl_t;

endpackage

`default_nettype wire

/* rtl/vesl_sermul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on vesl_pkg (mul_ctrl_t). Product of n steps is {hi,lo} >> (B_W - n).
`timescale 1ns / 1ps
`default_nettype none

module vesl_sermul #(
    parameter int A_W = vesl_pkg::MUL_A_W,
    parameter int B_W = vesl_pkg::MUL_B_W
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire vesl_pkg::mul_ctrl_t    ctrl,
    input  wire logic [A_W-1:0]         mcand,
    input  wire logic [B_W-1:0]         mplr,
    output logic [A_W+B_W-1:0]          prod,
    output logic                        done
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   mcand_reg, mcand_next;
    logic [A_W-1:0]   hi_reg, hi_next;
    logic [B_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [A_W:0]     sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb begin
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        done_next  = (cnt_reg == CNT_W'(1));
        if (ctrl.start) begin
            mcand_next = mcand;
            hi_next    = '0;
            lo_next    = mplr;
            cnt_next   = CNT_W'(ctrl.steps);
        end else if (cnt_reg != '0) begin
            // product bits shift down into the multiplier register
            hi_next  = sum[A_W:1];
            lo_next  = {sum[0], lo_reg[B_W-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign prod = {hi_reg, lo_reg};
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/vactrol_envelope_slew.sv */
// Vactrol-style envelope slew: top level, controller and state registers.
// Depends on vesl_pkg and vesl_sermul.
//
//   port group | dir | handshake        | fields
//   s_*        | in  | s_valid/s_ready  | s_target_valid, s_target
//   m_*        | out | m_valid/m_ready  | m_level_out, m_settled
//   cfg_*      | in  | cfg_wr_en        | cfg_index, cfg_wdata
//
// One word at a time: a word that moves the level runs three bit-serial products
// on one shared multiplier, level^2, rate*level^2 and gap*slew; a word that snaps
// skips them and goes straight from the decision state to the output state.
// Reset is synchronous, active low; state and registers take their reset values.
// A result waits in the output register; the next word is taken meanwhile and
// holds in the output state until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module vactrol_envelope_slew (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_target_valid,
    input  wire logic [vesl_pkg::LVL_W-1:0]     s_target,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [vesl_pkg::LVL_W-1:0]          m_level_out,
    output logic                                m_settled,
    input  wire logic                           cfg_wr_en,
    input  wire logic [vesl_pkg::CFGI_W-1:0]    cfg_index,
    input  wire logic [vesl_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int LW   = vesl_pkg::LVL_W;
    localparam int RW   = vesl_pkg::RATE_W;
    localparam int SW   = vesl_pkg::SLEW_W;
    localparam int AW   = vesl_pkg::MUL_A_W;
    localparam int BW   = vesl_pkg::MUL_B_W;
    localparam int PW   = AW + BW;
    localparam int SQ_W = 31;                       // level^2 <= 2^30
    localparam int SQ_LSB  = BW - 16;               // after 16 steps
    localparam int PSH_W   = 30;                    // (rate*level^2) >> 29
    localparam int PSH_LSB = BW - SQ_W + 29;        // after 31 steps
    localparam int DLT_LSB = BW - 16 + 24;          // (gap*slew) >> 24

    vesl_pkg::state_t state_reg, state_next;

    logic [vesl_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [RW-1:0] rise_rate_reg, rise_rate_next;
    logic [RW-1:0] fall_rate_reg, fall_rate_next;
    logic [LW-1:0] near_floor_reg, near_floor_next;

    logic [LW-1:0] level_reg, level_next;
    logic [LW-1:0] dest_reg, dest_next;
    logic [LW-1:0] peak_reg, peak_next;

    logic [RW-1:0] rate_reg, rate_next;
    logic [LW-1:0] mag_reg, mag_next;
    logic          gap_neg_reg, gap_neg_next;
    logic          settled_reg, settled_next;

    logic          m_valid_reg, m_valid_next;
    logic [LW-1:0] m_level_out_reg, m_level_out_next;
    logic          m_settled_reg, m_settled_next;

    vesl_pkg::mul_ctrl_t mul_ctrl;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_prod;
    logic          mul_done;

    // datapath terms
    logic          sustain, cyc_mode;
    logic [LW-1:0] t_sat;
    logic [LW:0]   gap;
    logic [LW:0]   gap_abs;
    logic          near;
    logic [SQ_W-1:0] sq;
    logic [SQ_W-1:0] slew_sum;
    logic [SW-1:0]   slew;
    logic [LW-1:0]   delta;
    logic [LW:0]     lvl_up, lvl_dn;

    vesl_sermul #(
        .A_W (AW),
        .B_W (BW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mul_ctrl),
        .mcand   (mul_a),
        .mplr    (mul_b),
        .prod    (mul_prod),
        .done    (mul_done)
    );

    assign sustain  = (mode_reg == vesl_pkg::MODE_SUSTAIN);
    assign cyc_mode = mode_reg[1];      // modes 2 and 3 oscillate

    assign t_sat   = (s_target > vesl_pkg::ONE_Q15) ? vesl_pkg::ONE_Q15 : s_target;
    assign gap     = {1'b0, dest_reg} - {1'b0, level_reg};
    assign gap_abs = gap[LW] ? ((LW+1)'(0) - gap) : gap;
    assign near    = (gap_abs[LW-1:0] < near_floor_reg);

    assign sq       = mul_prod[SQ_LSB +: SQ_W];
    assign slew_sum = {3'b000, rate_reg} + {1'b0, mul_prod[PSH_LSB +: PSH_W]};
    assign slew     = (slew_sum > {{(SQ_W-SW){1'b0}}, vesl_pkg::SLEW_MAX})
                      ? vesl_pkg::SLEW_MAX : slew_sum[SW-1:0];
    assign delta    = mul_prod[DLT_LSB +: LW];
    assign lvl_up   = {1'b0, level_reg} + {1'b0, delta};
    assign lvl_dn   = {1'b0, level_reg} - {1'b0, delta};

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        rise_rate_next   = rise_rate_reg;
        fall_rate_next   = fall_rate_reg;
        near_floor_next  = near_floor_reg;
        level_next       = level_reg;
        dest_next        = dest_reg;
        peak_next        = peak_reg;
        rate_next        = rate_reg;
        mag_next         = mag_reg;
        gap_neg_next     = gap_neg_reg;
        settled_next     = settled_reg;
        m_valid_next     = m_valid_reg;
        m_level_out_next = m_level_out_reg;
        m_settled_next   = m_settled_reg;
        mul_ctrl.start   = 1'b0;
        mul_ctrl.steps   = vesl_pkg::STEPS_LVL;
        mul_a            = '0;
        mul_b            = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            vesl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_target_valid) begin
                        if ((t_sat < level_reg) && !sustain) begin
                            dest_next = '0;
                        end else begin
                            dest_next = t_sat;
                        end
                        if (t_sat > near_floor_reg) begin
                            peak_next = t_sat;
                        end
                    end
                    state_next = vesl_pkg::ST_DECIDE;
                end
            end
            vesl_pkg::ST_DECIDE: begin
                // step uses the gap from before any change made here
                mag_next     = gap_abs[LW-1:0];
                gap_neg_next = gap[LW];
                settled_next = 1'b0;
                rate_next    = fall_rate_reg;
                if (!gap[LW] && (gap != '0)) begin
                    if (near) begin
                        if (!sustain) begin
                            dest_next = '0;
                        end else begin
                            settled_next = 1'b1;
                        end
                    end else begin
                        rate_next = rise_rate_reg;
                    end
                end else if (near) begin
                    if (cyc_mode) begin
                        if (dest_reg == peak_reg) begin
                            dest_next = '0;
                        end else begin
                            dest_next = peak_reg;
                            rate_next = rise_rate_reg;
                        end
                    end else if ((dest_reg == '0) || sustain) begin
                        settled_next = 1'b1;
                    end else begin
                        dest_next = '0;
                    end
                end
                if (settled_next) begin
                    level_next = dest_reg;
                    state_next = vesl_pkg::ST_OUTPUT;
                end else begin
                    mul_ctrl.start = 1'b1;
                    mul_ctrl.steps = vesl_pkg::STEPS_LVL;
                    mul_a          = AW'(level_reg);
                    mul_b          = BW'(level_reg);
                    state_next     = vesl_pkg::ST_SQUARE;
                end
            end
            vesl_pkg::ST_SQUARE: begin
                if (mul_done) begin
                    mul_ctrl.start = 1'b1;
                    mul_ctrl.steps = vesl_pkg::STEPS_SQ;
                    mul_a          = AW'(rate_reg);
                    mul_b          = BW'(sq);
                    state_next     = vesl_pkg::ST_SLEW;
                end
            end
            vesl_pkg::ST_SLEW: begin
                if (mul_done) begin
                    mul_ctrl.start = 1'b1;
                    mul_ctrl.steps = vesl_pkg::STEPS_LVL;
                    mul_a          = AW'(slew);
                    mul_b          = BW'(mag_reg);
                    state_next     = vesl_pkg::ST_STEP;
                end
            end
            vesl_pkg::ST_STEP: begin
                if (mul_done) begin
                    if (gap_neg_reg) begin
                        level_next = lvl_dn[LW] ? '0 : lvl_dn[LW-1:0];
                    end else begin
                        level_next = (lvl_up > {1'b0, vesl_pkg::ONE_Q15})
                                     ? vesl_pkg::ONE_Q15 : lvl_up[LW-1:0];
                    end
                    state_next = vesl_pkg::ST_OUTPUT;
                end
            end
            vesl_pkg::ST_OUTPUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_level_out_next = level_reg;
                    m_settled_next   = settled_reg;
                    state_next       = vesl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vesl_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                vesl_pkg::CFG_MODE: begin
                    mode_next = cfg_wdata[vesl_pkg::MODE_W-1:0];
                    if (cfg_wdata[vesl_pkg::MODE_W-1:0] != vesl_pkg::MODE_SUSTAIN) begin
                        dest_next = '0;
                    end
                end
                vesl_pkg::CFG_RISE_RATE:  rise_rate_next  = cfg_wdata[RW-1:0];
                vesl_pkg::CFG_FALL_RATE:  fall_rate_next  = cfg_wdata[RW-1:0];
                vesl_pkg::CFG_NEAR_FLOOR: near_floor_next = cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= vesl_pkg::ST_IDLE;
            mode_reg       <= vesl_pkg::RST_MODE;
            rise_rate_reg  <= vesl_pkg::RST_RISE_RATE;
            fall_rate_reg  <= vesl_pkg::RST_FALL_RATE;
            near_floor_reg <= vesl_pkg::RST_NEAR_FLOOR;
            level_reg      <= '0;
            dest_reg       <= '0;
            peak_reg       <= vesl_pkg::ONE_Q15;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            rise_rate_reg  <= rise_rate_next;
            fall_rate_reg  <= fall_rate_next;
            near_floor_reg <= near_floor_next;
            level_reg      <= level_next;
            dest_reg       <= dest_next;
            peak_reg       <= peak_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rate_reg        <= rate_next;
        mag_reg         <= mag_next;
        gap_neg_reg     <= gap_neg_next;
        settled_reg     <= settled_next;
        m_level_out_reg <= m_level_out_next;
        m_settled_reg   <= m_settled_next;
    end

    assign s_ready     = (state_reg == vesl_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_level_out = m_level_out_reg;
    assign m_settled   = m_settled_reg;

`ifndef SYNTHESIS
    // a snapped word carries the destination as its level
    a_snap_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vesl_pkg::ST_OUTPUT && settled_reg) |-> (level_reg == dest_reg))
        else $error("snapped level differs from destination");

    // level, destination and peak stay within 0..1.0
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (level_reg <= vesl_pkg::ONE_Q15) && (dest_reg <= vesl_pkg::ONE_Q15)
        && (peak_reg <= vesl_pkg::ONE_Q15))
        else $error("state register above 1.0");

    // a 16-step product from the decision state completes on schedule
    a_square_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vesl_pkg::ST_DECIDE && mul_ctrl.start) |-> ##17 mul_done)
        else $error("level square did not finish in 17 cycles");

    // the multiplier is never restarted while a product is in flight
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_ctrl.start && state_reg != vesl_pkg::ST_DECIDE) |-> mul_done)
        else $error("multiplier started before done");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking bench for vactrol_envelope_slew: directed envelope cases, then random
// traffic in three idle profiles, each word checked against an in-bench envelope predictor.
// Depends on rtl/vesl_pkg.sv, rtl/vesl_sermul.sv and rtl/vactrol_envelope_slew.sv.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES  = 100;
    localparam int SEG_WORDS    = 30;
    // bit 1 set also means cycle
    localparam logic [vesl_pkg::MODE_W-1:0] MODE_CYCLE_ALT = 2'd3;
    localparam logic [vesl_pkg::RATE_W-1:0] RATE_MAX = 28'hFFFFFFF;

    typedef struct packed {
        logic [vesl_pkg::LVL_W-1:0] level;
        logic                       settled;
    } tick_result_t;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_target_valid;
    logic [vesl_pkg::LVL_W-1:0]  s_target;
    logic                        m_valid;
    logic                        m_ready;
    logic [vesl_pkg::LVL_W-1:0]  m_level_out;
    logic                        m_settled;
    logic                        cfg_wr_en;
    logic [vesl_pkg::CFGI_W-1:0] cfg_index;
    logic [vesl_pkg::CFG_W-1:0]  cfg_wdata;

    // predictor copy of the block state and registers
    int                          env_level;
    int                          env_dest;
    int                          env_peak;
    logic [vesl_pkg::MODE_W-1:0] reg_mode;
    logic [vesl_pkg::RATE_W-1:0] reg_rise;
    logic [vesl_pkg::RATE_W-1:0] reg_fall;
    logic [vesl_pkg::LVL_W-1:0]  reg_floor;

    tick_result_t pending_levels[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count      = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int settled_seen    = 0;
    int cycle_count     = 0;

    vactrol_envelope_slew dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_valid (s_target_valid),
        .s_target       (s_target),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_level_out    (m_level_out),
        .m_settled      (m_settled),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_levels.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_levels.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected word: level %0d settled %0b", m_level_out, m_settled);
                fail_count++;
            end else begin
                want = pending_levels.pop_front();
                if (m_level_out !== want.level) begin
                    if (fail_count < 10)
                        $display("word %0d: level_out expected %0d, got %0d",
                                 results_checked, want.level, m_level_out);
                    fail_count++;
                end
                if (m_settled !== want.settled) begin
                    if (fail_count < 10)
                        $display("word %0d: settled expected %0b, got %0b",
                                 results_checked, want.settled, m_settled);
                    fail_count++;
                end
                if (want.settled)
                    settled_seen++;
                results_checked++;
            end
        end
    end

    function automatic void reset_envelope();
        env_level = 0;
        env_dest  = 0;
        env_peak  = int'(vesl_pkg::ONE_Q15);
        reg_mode  = vesl_pkg::RST_MODE;
        reg_rise  = vesl_pkg::RST_RISE_RATE;
        reg_fall  = vesl_pkg::RST_FALL_RATE;
        reg_floor = vesl_pkg::RST_NEAR_FLOOR;
    endfunction

    function automatic void apply_reg(input logic [vesl_pkg::CFGI_W-1:0] idx,
                                      input logic [vesl_pkg::CFG_W-1:0] val);
        case (idx)
            vesl_pkg::CFG_MODE: begin
                reg_mode = val[vesl_pkg::MODE_W-1:0];
                if (reg_mode != vesl_pkg::MODE_SUSTAIN)
                    env_dest = 0;
            end
            vesl_pkg::CFG_RISE_RATE:  reg_rise  = val[vesl_pkg::RATE_W-1:0];
            vesl_pkg::CFG_FALL_RATE:  reg_fall  = val[vesl_pkg::RATE_W-1:0];
            vesl_pkg::CFG_NEAR_FLOOR: reg_floor = val[vesl_pkg::LVL_W-1:0];
            default: ;
        endcase
    endfunction

    // one sample tick of the envelope
    function automatic tick_result_t advance_envelope(input logic tv,
                                                      input logic [vesl_pkg::LVL_W-1:0] tgt);
        tick_result_t res;
        logic         cyc;
        logic         sus;
        logic         snap;
        int           flr;
        int           t;
        int           gap;
        int           delta;
        logic [vesl_pkg::RATE_W-1:0] rate;
        logic [63:0]  lv;
        logic [63:0]  shape;
        logic [63:0]  slew;
        logic [63:0]  mag;

        cyc  = reg_mode[1];
        sus  = (reg_mode == vesl_pkg::MODE_SUSTAIN);
        flr  = int'(reg_floor);
        snap = 1'b0;
        rate = reg_fall;
        if (tv) begin
            t = int'(tgt);
            if (t > int'(vesl_pkg::ONE_Q15))
                t = int'(vesl_pkg::ONE_Q15);
            if (t < env_level && !sus)
                env_dest = 0;
            else
                env_dest = t;
            if (t > flr)
                env_peak = t;
        end

        // step uses this gap even if the destination turns below
        gap = env_dest - env_level;
        if (gap > 0) begin
            if (gap < flr) begin
                if (!sus) begin
                    env_dest = 0;
                    rate = reg_fall;
                end else begin
                    snap = 1'b1;
                end
            end else begin
                rate = reg_rise;
            end
        end else if (gap > -flr) begin
            if (cyc) begin
                if (env_dest == env_peak) begin
                    env_dest = 0;
                    rate = reg_fall;
                end else begin
                    env_dest = env_peak;
                    rate = reg_rise;
                end
            end else if (env_dest == 0 || sus) begin
                snap = 1'b1;
            end else begin
                env_dest = 0;
                rate = reg_fall;
            end
        end else begin
            rate = reg_fall;
        end

        if (snap) begin
            env_level = env_dest;
        end else begin
            lv    = 64'(env_level);
            shape = (64'd1 << 30) + 64'd2 * lv * lv;
            slew  = (64'(rate) * shape) >> 30;
            if (slew > 64'(vesl_pkg::SLEW_MAX))
                slew = 64'(vesl_pkg::SLEW_MAX);
            mag   = 64'(gap < 0 ? -gap : gap);
            delta = int'((mag * slew) >> 24);
            env_level = (gap < 0) ? env_level - delta : env_level + delta;
            if (env_level < 0)
                env_level = 0;
            if (env_level > int'(vesl_pkg::ONE_Q15))
                env_level = int'(vesl_pkg::ONE_Q15);
        end
        res.level   = env_level[vesl_pkg::LVL_W-1:0];
        res.settled = snap;
        return res;
    endfunction

    task automatic send_word(input logic tv, input logic [vesl_pkg::LVL_W-1:0] tgt);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_target_valid <= tv;
        s_target       <= tgt;
        do @(posedge aclk); while (!s_ready);
        pending_levels.push_back(advance_envelope(tv, tgt));
        words_sent++;
    endtask

    // hold the sender until every outstanding word is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_levels.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // caller makes sure the block is idle
    task automatic write_reg(input logic [vesl_pkg::CFGI_W-1:0] idx,
                             input logic [vesl_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_sustain_moves();
        send_word(1'b0, '0);                    // at rest on zero: snaps and holds
        drain_results();
        write_reg(vesl_pkg::CFG_RISE_RATE, vesl_pkg::CFG_W'(RATE_MAX));
        write_reg(vesl_pkg::CFG_FALL_RATE, vesl_pkg::CFG_W'(28'd2000000));
        send_word(1'b1, vesl_pkg::ONE_Q15);
        send_word(1'b0, '0);
        send_word(1'b1, 16'hFFFF);              // above one, saturates
        send_word(1'b1, 16'd0);
        send_word(1'b0, '0);
        send_word(1'b1, 16'(env_level + 10));   // inside the floor
    endtask

    task automatic test_transient_decay();
        drain_results();
        write_reg(vesl_pkg::CFG_MODE, vesl_pkg::CFG_W'(vesl_pkg::MODE_TRANSIENT));
        send_word(1'b1, 16'd20000);
        send_word(1'b0, '0);
        send_word(1'b0, '0);
        send_word(1'b1, 16'd5000);              // below level: heads for zero
        send_word(1'b0, '0);
    endtask

    task automatic test_cycle_reversal();
        drain_results();
        write_reg(vesl_pkg::CFG_MODE, vesl_pkg::CFG_W'(vesl_pkg::MODE_CYCLE));
        write_reg(vesl_pkg::CFG_FALL_RATE, vesl_pkg::CFG_W'(RATE_MAX));
        write_reg(vesl_pkg::CFG_NEAR_FLOOR, vesl_pkg::CFG_W'(16'd4000));
        send_word(1'b1, 16'd16000);
        send_word(1'b0, '0);
        send_word(1'b0, '0);
        send_word(1'b0, '0);
        drain_results();
        write_reg(vesl_pkg::CFG_MODE, vesl_pkg::CFG_W'(MODE_CYCLE_ALT));
        send_word(1'b0, '0);
        send_word(1'b1, 16'd30000);
    endtask

    task automatic test_floor_extremes();
        drain_results();
        write_reg(vesl_pkg::CFG_NEAR_FLOOR, vesl_pkg::CFG_W'(16'd0));
        write_reg(vesl_pkg::CFG_RISE_RATE, vesl_pkg::CFG_W'(28'd0));
        write_reg(vesl_pkg::CFG_FALL_RATE, vesl_pkg::CFG_W'(28'd0));
        send_word(1'b1, 16'd1000);              // zero rate: level stays
        send_word(1'b0, '0);
        drain_results();
        write_reg(vesl_pkg::CFG_NEAR_FLOOR, vesl_pkg::CFG_W'(vesl_pkg::ONE_Q15));
        write_reg(vesl_pkg::CFG_RISE_RATE, vesl_pkg::CFG_W'(28'd1));
        send_word(1'b1, vesl_pkg::ONE_Q15);
        send_word(1'b0, '0);
    endtask

    function automatic logic [vesl_pkg::RATE_W-1:0] pick_rate();
        case ($urandom_range(9))
            0:       return '0;
            1:       return RATE_MAX;
            2, 3:    return vesl_pkg::RATE_W'($urandom_range(0, RATE_MAX));
            default: return vesl_pkg::RATE_W'($urandom_range(100000, 3500000));
        endcase
    endfunction

    function automatic logic [vesl_pkg::LVL_W-1:0] pick_floor();
        case ($urandom_range(9))
            0:       return '0;
            1:       return vesl_pkg::ONE_Q15;
            2:       return vesl_pkg::LVL_W'($urandom_range(0, 32768));
            default: return vesl_pkg::LVL_W'($urandom_range(8, 1500));
        endcase
    endfunction

    function automatic logic [vesl_pkg::LVL_W-1:0] pick_target();
        int t;
        case ($urandom_range(15))
            0:       t = $urandom_range(32769, 65535);
            1:       t = 0;
            2:       t = 32768;
            3, 4, 5: begin
                // land near the level to hit the floor cases
                t = env_level + $urandom_range(0, 2 * int'(reg_floor) + 2) - int'(reg_floor) - 1;
                if (t < 0)
                    t = 0;
                if (t > 32768)
                    t = 32768;
            end
            default: t = $urandom_range(0, 32768);
        endcase
        return vesl_pkg::LVL_W'(t);
    endfunction

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int segments);
        logic [vesl_pkg::MODE_W-1:0] m;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int seg = 0; seg < segments; seg++) begin
            drain_results();
            m = ($urandom_range(7) == 0) ? MODE_CYCLE_ALT
                                         : vesl_pkg::MODE_W'($urandom_range(0, 2));
            write_reg(vesl_pkg::CFG_RISE_RATE, vesl_pkg::CFG_W'(pick_rate()));
            write_reg(vesl_pkg::CFG_FALL_RATE, vesl_pkg::CFG_W'(pick_rate()));
            write_reg(vesl_pkg::CFG_NEAR_FLOOR, vesl_pkg::CFG_W'(pick_floor()));
            write_reg(vesl_pkg::CFG_MODE, vesl_pkg::CFG_W'(m));
            for (int i = 0; i < SEG_WORDS; i++) begin
                if (i == SEG_WORDS / 2 && $urandom_range(3) == 0)
                    drain_results();
                if ($urandom_range(99) < 20)
                    send_word(1'b1, pick_target());
                else
                    send_word(1'b0, vesl_pkg::LVL_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_target_valid <= 1'b0;
        s_target       <= '0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        reset_envelope();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_sustain_moves();
        test_transient_decay();
        test_cycle_reversal();
        test_floor_extremes();
        test_random_traffic(15, 84, 6);
        test_random_traffic(84, 15, 6);
        test_random_traffic(0, 0, 6);

        s_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        fail_count += pending_levels.size();

        $display("Run covered %0d words over sustain, transient and cycle modes with", words_sent);
        $display("random rates and floors; %0d results checked, %0d snapped, %0d failures",
                 results_checked, settled_seen, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/vesl_pkg.sv
rtl/vesl_sermul.sv
rtl/vactrol_envelope_slew.sv
sim/tb.sv
